// ===== src/bscp_pkg.sv =====
package bscp_pkg;

  localparam int TOKEN_W = 20;
  localparam int RANGE_W = 21;
  localparam int POS_W   = 12;
  localparam int RANK_W  = 13;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [1:0] KIND_PAD  = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_SELF = 2'd2;
  localparam logic [1:0] KIND_ORD  = 2'd3;

  localparam logic [2:0] REG_OPEN_LOW  = 3'd0;
  localparam logic [2:0] REG_OPEN_END  = 3'd1;
  localparam logic [2:0] REG_CLOSE_LOW = 3'd2;
  localparam logic [2:0] REG_CLOSE_END = 3'd3;
  localparam logic [2:0] REG_PAD_TOKEN = 3'd4;
  localparam logic [2:0] REG_AUG_MODE  = 3'd5;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [1:0]        kind;
    logic [POS_W-1:0]  key_pos;
    logic              slot;
    logic [RANK_W-1:0] query_rank;
    logic [RANK_W-1:0] key_rank;
    logic [RANK_W-1:0] prefix;
    logic              self_mark;
    logic              keep;
    logic              ovf;
    logic              last;
  } row_t;

endpackage

// ===== src/bracket_stack_compose_parser_top.sv =====
// Bracket stack compose parser.
// Input channel (in_valid/in_stall) carries one token per transaction with
// its segment_start and first_run_even flags. Output channel
// (out_valid/out_stall) carries result rows; last_of_run marks the final row
// caused by one token. Configuration registers sit on the APB port at byte
// addresses 0x00..0x14, pready is tied high.
// Pad and ordinary tokens: the row is registered and appears in the cycle after
// the accept, one token per cycle when the output is not stalled.
// Compose tokens: an optional S_BASE state fetches the base link under the popped
// run, each popped key passes through S_READ (RAM read) and S_EMIT (emit), and the
// compose row through S_READ (end check) and S_SELF (emit); S_EMIT and S_SELF wait
// while the output is stalled, and the next token is taken once back in S_IDLE.
// The stack is one single-port-write RAM with a registered read; each entry
// links to the nearest opening entry at or below it: no search for the pop boundary.
// A single output register sits between the sides; a new token is taken
// while a finished row waits, as long as that row is taken in the same cycle
// or the register is empty. When out_stall is high the row holds and the
// parser pauses in place.
// Reset clears the configuration registers, the stack pointer, the counters and the last
// token; the stack RAM is not cleared (only entries below the top are read).
module bracket_stack_compose_parser_top
  import bscp_pkg::*;
#(
  parameter int SEQ_LEN     = 4096,
  parameter int STACK_DEPTH = 63
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TOKEN_W-1:0]  token,
  input  logic                segment_start,
  input  logic                first_run_even,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [POS_W-1:0]    position,
  output logic [1:0]          row_kind,
  output logic [POS_W-1:0]    key_position,
  output logic                consumer_slot,
  output logic [RANK_W-1:0]   query_rank,
  output logic [RANK_W-1:0]   key_rank,
  output logic [RANK_W-1:0]   prefix_length,
  output logic                self_mark,
  output logic                label_keep,
  output logic                stack_overflow,
  output logic                last_of_run
);

  localparam int PW = $clog2(SEQ_LEN);
  localparam int CW = $clog2(SEQ_LEN + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_SELF = 3'd4;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             is_open;
    logic             is_comp;
    logic             base_ok;
    logic [AW-1:0]    base;
  } entry_t;

  logic [RANGE_W-1:0] open_low, open_end, close_low, close_end;
  logic [TOKEN_W-1:0] pad_token;
  logic               augmented_mode;

  logic [2:0]         state;
  logic [TW-1:0]      stack_top;
  logic [AW-1:0]      top_base;
  logic               top_base_ok;
  logic [TOKEN_W-1:0] last_token;
  logic               last_valid;
  logic [PW-1:0]      pos_cnt;
  logic [CW-1:0]      key_cnt;
  logic [CW-1:0]      query_cnt;
  logic               out_valid_r;
  row_t               out_row;

  logic [POS_W-1:0]   c_pos;
  logic [RANK_W-1:0]  c_qrank, c_krank;
  logic               c_ovf, c_open, base_pend;
  logic [TW-1:0]      c_b, idx, pop_end;

  entry_t             stack_mem [STACK_DEPTH];
  entry_t             rd_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;

  logic               out_free, accept, cfg_wr;
  logic [TW-1:0]      eff_top;
  logic               eff_base_ok, eff_last_valid;
  logic [PW-1:0]      eff_pos, pos_cnt_next;
  logic [CW-1:0]      eff_key, eff_query, kc_inc, qc_inc, kc_ord;
  logic [POS_W-1:0]   pos12;
  logic               is_pad, is_open, is_close, is_comp, full;
  logic [TW-1:0]      b;
  logic               comp_ovf, ord_ovf;
  entry_t             ord_entry, comp_entry;
  logic               out_load;
  row_t               out_row_next;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case (paddr[4:2])
      REG_OPEN_LOW:  prdata = DATA_W'(open_low);
      REG_OPEN_END:  prdata = DATA_W'(open_end);
      REG_CLOSE_LOW: prdata = DATA_W'(close_low);
      REG_CLOSE_END: prdata = DATA_W'(close_end);
      REG_PAD_TOKEN: prdata = DATA_W'(pad_token);
      REG_AUG_MODE:  prdata = DATA_W'(augmented_mode);
      default:       prdata = '0;
    endcase
  end

  // segment_start clears state ahead of the token
  assign eff_top        = segment_start ? '0 : stack_top;
  assign eff_base_ok    = !segment_start && top_base_ok;
  assign eff_last_valid = !segment_start && last_valid;
  assign eff_pos        = segment_start ? '0 : pos_cnt;
  assign eff_key        = segment_start ? '0 : key_cnt;
  assign eff_query      = segment_start ? '0 : query_cnt;
  assign pos_cnt_next   = (eff_pos == PW'(SEQ_LEN - 1)) ? '0 : eff_pos + 1'b1;
  assign kc_inc         = (eff_key == CW'(SEQ_LEN)) ? eff_key : eff_key + 1'b1;
  assign qc_inc         = (eff_query == CW'(SEQ_LEN)) ? eff_query : eff_query + 1'b1;
  assign pos12          = POS_W'(eff_pos);

  assign is_pad   = token == pad_token;
  assign is_open  = (open_low <= {1'b0, token}) && ({1'b0, token} < open_end);
  assign is_close = (close_low <= {1'b0, token}) && ({1'b0, token} < close_end);
  assign is_comp  = is_close && (eff_last_valid ? (last_token != token) : first_run_even);
  assign full     = eff_top == TW'(STACK_DEPTH);

  // pop boundary: nearest opening entry (stack bottom if none), or nothing when the token opens
  assign b        = is_open ? eff_top : (eff_base_ok ? TW'(top_base) : '0);
  assign comp_ovf = is_open && full;
  assign ord_ovf  = !is_close && full;
  assign kc_ord   = is_close ? eff_key : kc_inc;

  always_comb begin
    ord_entry.pos     = pos12;
    ord_entry.is_open = is_open;
    ord_entry.is_comp = 1'b0;
    ord_entry.base_ok = is_open || eff_base_ok;
    ord_entry.base    = is_open ? eff_top[AW-1:0] : top_base;
    comp_entry.pos     = c_pos;
    comp_entry.is_open = c_open;
    comp_entry.is_comp = 1'b1;
    comp_entry.base_ok = c_open || top_base_ok;
    comp_entry.base    = c_open ? c_b[AW-1:0] : top_base;
  end

  always_comb begin
    out_load     = 1'b0;
    out_row_next = out_row;
    unique case (state)
      S_IDLE: begin
        if (accept && !(is_comp && !is_pad)) begin
          out_load                = 1'b1;
          out_row_next.pos        = pos12;
          out_row_next.key_pos    = pos12;
          out_row_next.slot       = 1'b0;
          out_row_next.query_rank = RANK_W'(eff_query);
          out_row_next.key_rank   = RANK_W'(eff_key);
          out_row_next.last       = 1'b1;
          if (is_pad) begin
            out_row_next.kind      = KIND_PAD;
            out_row_next.prefix    = '0;
            out_row_next.self_mark = 1'b0;
            out_row_next.keep      = 1'b1;
            out_row_next.ovf       = 1'b0;
          end else begin
            out_row_next.kind      = KIND_ORD;
            out_row_next.prefix    = augmented_mode ? RANK_W'(pos12) + 1'b1
                                                    : RANK_W'(kc_ord);
            out_row_next.self_mark = is_close && !augmented_mode;
            out_row_next.keep      = !is_close;
            out_row_next.ovf       = ord_ovf;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_row_next.pos        = c_pos;
          out_row_next.kind       = KIND_POP;
          out_row_next.key_pos    = rd_data.pos;
          out_row_next.slot       = rd_data.is_comp;
          out_row_next.query_rank = c_qrank;
          out_row_next.key_rank   = c_krank;
          out_row_next.prefix     = '0;
          out_row_next.self_mark  = 1'b0;
          out_row_next.keep       = 1'b1;
          out_row_next.ovf        = c_ovf;
          out_row_next.last       = 1'b0;
        end
      end
      S_SELF: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_row_next.pos        = c_pos;
          out_row_next.kind       = KIND_SELF;
          out_row_next.key_pos    = c_pos;
          out_row_next.slot       = 1'b0;
          out_row_next.query_rank = c_qrank;
          out_row_next.key_rank   = c_krank;
          out_row_next.prefix     = '0;
          out_row_next.self_mark  = 1'b0;
          out_row_next.keep       = 1'b1;
          out_row_next.ovf        = c_ovf;
          out_row_next.last       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_en   = (state == S_BASE) || (state == S_READ && idx < pop_end);
    rd_addr = (state == S_BASE) ? (c_b[AW-1:0] - 1'b1) : idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = eff_top[AW-1:0];
    wr_data = ord_entry;
    if (state == S_IDLE && accept && !is_pad && !is_comp && !is_close && !full) begin
      wr_en = 1'b1;
    end else if (state == S_SELF && out_free && !c_ovf) begin
      wr_en   = 1'b1;
      wr_addr = c_b[AW-1:0];
      wr_data = comp_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row <= out_row_next;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          c_pos     <= pos12;
          c_qrank   <= RANK_W'(eff_query);
          c_krank   <= RANK_W'(eff_key);
          c_ovf     <= comp_ovf;
          c_open    <= is_open;
          c_b       <= b;
          idx       <= b;
          pop_end   <= eff_top;
          base_pend <= !is_open && (b != '0);
        end
      end
      S_READ: begin
        base_pend <= 1'b0;
      end
      S_EMIT: begin
        if (out_free) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid_r    <= 1'b0;
      open_low       <= '0;
      open_end       <= '0;
      close_low      <= '0;
      close_end      <= '0;
      pad_token      <= '0;
      augmented_mode <= 1'b0;
      stack_top      <= '0;
      top_base       <= '0;
      top_base_ok    <= 1'b0;
      last_token     <= '0;
      last_valid     <= 1'b0;
      pos_cnt        <= '0;
      key_cnt        <= '0;
      query_cnt      <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_OPEN_LOW:  open_low       <= pwdata[RANGE_W-1:0];
          REG_OPEN_END:  open_end       <= pwdata[RANGE_W-1:0];
          REG_CLOSE_LOW: close_low      <= pwdata[RANGE_W-1:0];
          REG_CLOSE_END: close_end      <= pwdata[RANGE_W-1:0];
          REG_PAD_TOKEN: pad_token      <= pwdata[TOKEN_W-1:0];
          REG_AUG_MODE:  augmented_mode <= pwdata[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos_cnt     <= pos_cnt_next;
            stack_top   <= eff_top;
            top_base_ok <= eff_base_ok;
            key_cnt     <= eff_key;
            query_cnt   <= eff_query;
            last_valid  <= eff_last_valid;
            if (is_pad) begin
            end else if (is_comp) begin
              key_cnt     <= kc_inc;
              last_token  <= token;
              last_valid  <= 1'b1;
              top_base_ok <= is_open && eff_base_ok;
              state       <= (!is_open && b != '0) ? S_BASE : S_READ;
            end else begin
              key_cnt    <= kc_ord;
              query_cnt  <= qc_inc;
              last_token <= token;
              last_valid <= 1'b1;
              if (!is_close && !full) begin
                stack_top   <= eff_top + 1'b1;
                top_base    <= ord_entry.base;
                top_base_ok <= ord_entry.base_ok;
              end
            end
          end
        end
        S_BASE: begin
          state <= S_READ;
        end
        S_READ: begin
          if (base_pend) begin
            top_base    <= rd_data.base;
            top_base_ok <= rd_data.base_ok;
          end
          state <= (idx < pop_end) ? S_EMIT : S_SELF;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_READ;
          end
        end
        S_SELF: begin
          if (out_free) begin
            state <= S_IDLE;
            if (!c_ovf) begin
              stack_top   <= c_b + 1'b1;
              top_base    <= comp_entry.base;
              top_base_ok <= comp_entry.base_ok;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign position       = out_row.pos;
  assign row_kind       = out_row.kind;
  assign key_position   = out_row.key_pos;
  assign consumer_slot  = out_row.slot;
  assign query_rank     = out_row.query_rank;
  assign key_rank       = out_row.key_rank;
  assign prefix_length  = out_row.prefix;
  assign self_mark      = out_row.self_mark;
  assign label_keep     = out_row.keep;
  assign stack_overflow = out_row.ovf;
  assign last_of_run    = out_row.last;

`ifndef SYNTH
  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    stack_top <= TW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall)
    else $error("input taken during compose");

  a_base_below_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && top_base_ok) |-> (TW'(top_base) < stack_top))
    else $error("base link points above stack top");

  a_emit_in_run: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> idx < pop_end)
    else $error("emit past popped run");

  a_self_is_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SELF && out_free) |=> (out_valid && last_of_run && row_kind == KIND_SELF))
    else $error("compose row not closing the transaction");
`endif

endmodule
